// ===== src/dts_pkg.sv =====
`timescale 1ns / 1ps
package dts_pkg;

   // Command codes as they arrive on the request channel.
   typedef enum logic [2:0] {
      OP_CHECK   = 3'd0,
      OP_CREATE  = 3'd1,
      OP_DELETE  = 3'd2,
      OP_START   = 3'd3,
      OP_PAUSE   = 3'd4,
      OP_PERIOD  = 3'd5,
      OP_RELOAD  = 3'd6,
      OP_UNKNOWN = 3'd7
   } op_type;

   localparam logic [62:0] NEVER_DEADLINE = {63{1'b1}};
   localparam logic [31:0] WAIT_FOREVER   = 32'hFFFF_FFFF;
   localparam logic [31:0] WAIT_MAX       = 32'hFFFF_FFFE;
   localparam logic [31:0] PRECISION_RST  = 32'd1;

   localparam logic RESULT_EXPIRY  = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   // A classified command word handed from the front to the back.
   typedef struct packed {
      op_type      op;
      logic [3:0]  slot;
      logic [31:0] arg;
      logic [62:0] now;
      logic        bad;
   } cmd_type;

   // One result word.
   typedef struct packed {
      logic        kind;
      logic [3:0]  slot;
      logic [31:0] wait_us;
      logic        status;
      logic        last;
   } rsp_type;

endpackage

// ===== src/dts_front.sv =====
`timescale 1ns / 1ps
module dts_front import dts_pkg::*; #(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_timer_slot,
   input  logic [31:0] req_arg_value,
   input  logic [62:0] req_time_now,
   output logic        cmd_valid,
   input  logic        cmd_pop,
   output cmd_type     cmd_word
);

   cmd_type    mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic [8:0] slot_wide;
   logic       do_push, do_pop;

   // Classify: unknown codes and absent slots are marked bad up front.
   always_comb begin
      slot_wide = {5'd0, req_timer_slot};
      cls.op    = op_type'(req_type);
      cls.slot  = req_timer_slot;
      cls.arg   = req_arg_value;
      cls.now   = req_time_now;
      cls.bad   = (cls.op == OP_UNKNOWN) ||
                  ((cls.op != OP_CHECK) && (slot_wide >= 9'(NUM_TIMERS)));
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_word  = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= cls;
      end
   end

endmodule

// ===== src/dts_rsp_queue.sv =====
`timescale 1ns / 1ps
module dts_rsp_queue import dts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   output logic    q_full,
   input  rsp_type wr_word,
   output logic    empty,
   input  logic    pop,
   output rsp_type rd_word
);

   rsp_type    mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign q_full  = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign rd_word = mem_ff[rd_ff];
   assign do_push = wr_en && !q_full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wr_word;
      end
   end

endmodule

// ===== src/dts_back.sv =====
`timescale 1ns / 1ps
module dts_back import dts_pkg::*; #(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata,
   input  logic        cmd_valid,
   output logic        cmd_pop,
   input  cmd_type     cmd_word,
   output logic        rsp_wr,
   input  logic        rsp_full,
   output rsp_type     rsp_word
);

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_APPLY  = 5'b00010,
      S_SCAN   = 5'b00100,
      S_DECIDE = 5'b01000,
      S_FINAL  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic        status_ff, status_in;
   logic [31:0] prec_ff;
   logic [31:0] cnt_ff;
   logic [IW-1:0] idx_ff, idx_in, best_ff, best_in;
   logic        bvalid_ff, bvalid_in;
   logic        final_ff, final_in;

   logic          used_ff   [NUM_TIMERS];
   logic          en_ff     [NUM_TIMERS];
   logic          rl_ff     [NUM_TIMERS];
   logic [31:0]   per_ff    [NUM_TIMERS];
   logic [62:0]   dl_ff     [NUM_TIMERS];
   logic [31:0]   st_ff     [NUM_TIMERS];
   logic          fired_ff  [NUM_TIMERS];

   logic [8:0]    slot_wide;
   logic [IW-1:0] si;
   logic          cand, earlier, due, fire_now, apply_ok;
   logic [63:0]   due_lim, sched_sum, diff;
   logic [62:0]   sched_dl;
   logic [IW-1:0] sched_idx;
   logic          sched_en;
   logic [31:0]   wait_val;
   logic [8:0]    best_wide;

   assign csr_ready = 1'b1;
   assign slot_wide = {5'd0, cmd_ff.slot};
   assign si        = slot_wide[IW-1:0];
   assign best_wide = 9'(best_ff);

   // Compare the slot under the scan pointer against the best so far.
   always_comb begin
      cand = en_ff[idx_ff] && !(!final_ff && fired_ff[idx_ff]);
      earlier = (dl_ff[idx_ff] < dl_ff[best_ff]) ||
                ((dl_ff[idx_ff] == dl_ff[best_ff]) && (st_ff[idx_ff] > st_ff[best_ff]));
   end

   // Due test and the summary wait for the chosen slot.
   always_comb begin
      due_lim = {1'b0, cmd_ff.now} + {32'd0, prec_ff};
      due     = bvalid_ff && ({1'b0, dl_ff[best_ff]} < due_lim);
      diff    = {1'b0, dl_ff[best_ff]} - {1'b0, cmd_ff.now};
      if (!bvalid_ff) begin
         wait_val = WAIT_FOREVER;
      end else if (dl_ff[best_ff] <= cmd_ff.now) begin
         wait_val = 32'd0;
      end else if (diff > {32'd0, WAIT_MAX}) begin
         wait_val = WAIT_MAX;
      end else begin
         wait_val = diff[31:0];
      end
   end

   assign apply_ok = !status_in && (cmd_ff.op != OP_CHECK);
   assign fire_now = (state_ff == S_DECIDE) && !final_ff && due && !rsp_full;

   // Rescheduling: from a start or set period, or from a reload timer firing.
   always_comb begin
      sched_en  = 1'b0;
      sched_idx = si;
      if (state_ff == S_APPLY && apply_ok) begin
         if (cmd_ff.op == OP_START && !en_ff[si]) begin
            sched_en = 1'b1;
         end
         if (cmd_ff.op == OP_PERIOD && en_ff[si]) begin
            sched_en = 1'b1;
         end
      end
      if (fire_now && rl_ff[best_ff]) begin
         sched_en  = 1'b1;
         sched_idx = best_ff;
      end
      sched_sum = {1'b0, cmd_ff.now} +
                  {32'd0, ((state_ff == S_APPLY && cmd_ff.op == OP_PERIOD) ?
                           cmd_ff.arg : per_ff[sched_idx])};
      sched_dl  = sched_sum[63] ? NEVER_DEADLINE : sched_sum[62:0];
   end

   // Sequencer: apply, then scan passes until nothing more is due, then summary.
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      best_in   = best_ff;
      bvalid_in = bvalid_ff;
      final_in  = final_ff;
      cmd_pop   = 1'b0;
      rsp_wr    = 1'b0;
      rsp_word.kind    = RESULT_EXPIRY;
      rsp_word.slot    = best_wide[3:0];
      rsp_word.wait_us = 32'd0;
      rsp_word.status  = status_ff;
      rsp_word.last    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_word;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            state_in  = S_SCAN;
            idx_in    = '0;
            bvalid_in = 1'b0;
            final_in  = 1'b0;
         end
         S_SCAN: begin
            if (cand && (!bvalid_ff || earlier)) begin
               best_in   = idx_ff;
               bvalid_in = 1'b1;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = S_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DECIDE: begin
            if (!final_ff && !due) begin
               final_in  = 1'b1;
               state_in  = S_SCAN;
               idx_in    = '0;
               bvalid_in = 1'b0;
            end else if (!rsp_full) begin
               rsp_wr = 1'b1;
               if (final_ff) begin
                  rsp_word.kind    = RESULT_SUMMARY;
                  rsp_word.slot    = 4'd0;
                  rsp_word.wait_us = wait_val;
                  rsp_word.last    = 1'b1;
                  state_in         = S_IDLE;
               end else begin
                  state_in  = S_SCAN;
                  idx_in    = '0;
                  bvalid_in = 1'b0;
               end
            end
         end
         S_FINAL: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The command status is settled in the apply state, after the command is taken.
   always_comb begin
      status_in = status_ff;
      if (state_ff == S_APPLY) begin
         status_in = cmd_ff.bad ||
                     ((cmd_ff.op != OP_CHECK) && (cmd_ff.op != OP_CREATE) && !used_ff[si]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= 1'b0;
         idx_ff    <= '0;
         best_ff   <= '0;
         bvalid_ff <= 1'b0;
         final_ff  <= 1'b0;
         prec_ff   <= PRECISION_RST;
         cnt_ff    <= 32'd0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         idx_ff    <= idx_in;
         best_ff   <= best_in;
         bvalid_ff <= bvalid_in;
         final_ff  <= final_in;
         if (csr_valid) begin
            prec_ff <= csr_wdata;
         end
         if (sched_en) begin
            cnt_ff <= cnt_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   // Slot table. The status decision uses the value computed this cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            used_ff[i]  <= 1'b0;
            en_ff[i]    <= 1'b0;
            rl_ff[i]    <= 1'b0;
            dl_ff[i]    <= NEVER_DEADLINE;
            st_ff[i]    <= 32'd0;
            fired_ff[i] <= 1'b0;
         end
      end else begin
         if (state_ff == S_APPLY) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
               fired_ff[i] <= 1'b0;
            end
            if (!status_in && cmd_ff.op != OP_CHECK) begin
               case (cmd_ff.op)
                  OP_CREATE: begin
                     used_ff[si] <= 1'b1;
                     en_ff[si]   <= 1'b0;
                     rl_ff[si]   <= 1'b1;
                     dl_ff[si]   <= NEVER_DEADLINE;
                  end
                  OP_DELETE: begin
                     used_ff[si] <= 1'b0;
                     en_ff[si]   <= 1'b0;
                     rl_ff[si]   <= 1'b0;
                     dl_ff[si]   <= NEVER_DEADLINE;
                  end
                  OP_START: begin
                     en_ff[si] <= 1'b1;
                  end
                  OP_PAUSE: begin
                     if (en_ff[si]) begin
                        en_ff[si] <= 1'b0;
                        dl_ff[si] <= NEVER_DEADLINE;
                     end
                  end
                  OP_RELOAD: begin
                     rl_ff[si] <= (cmd_ff.arg != 32'd0);
                  end
                  default: begin
                  end
               endcase
            end
         end
         if (fire_now) begin
            fired_ff[best_ff] <= 1'b1;
            if (!rl_ff[best_ff]) begin
               en_ff[best_ff] <= 1'b0;
               dl_ff[best_ff] <= NEVER_DEADLINE;
            end
         end
         if (sched_en && (state_ff != S_APPLY || !status_in)) begin
            dl_ff[sched_idx] <= sched_dl;
            st_ff[sched_idx] <= cnt_ff;
         end
      end
   end

   // Periods need no reset; only used slots read them.
   always_ff @(posedge clock) begin
      if (state_ff == S_APPLY && !status_in &&
          (cmd_ff.op == OP_CREATE || cmd_ff.op == OP_PERIOD)) begin
         per_ff[si] <= cmd_ff.arg;
      end
   end

endmodule

// ===== src/deadline_timer_scheduler_top.sv =====
`timescale 1ns / 1ps
// A command is applied, then the slot scan runs passes until nothing more is due, then a final pass
// gives the summary; each pass visits one slot per cycle and is then decided, firing at most one timer.
// Throughput: one command at a time in the back end; two commands queue up in front of it.
// Results pass through a two-word queue, so a stalled reader holds the back end only when full.
// Reset is synchronous and active high: all slots unused, deadlines never, precision 1.
module deadline_timer_scheduler_top import dts_pkg::*; #(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_timer_slot,
   input  logic [31:0] req_arg_value,
   input  logic [62:0] req_time_now,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_result_kind,
   output logic [3:0]  rsp_fired_slot,
   output logic [31:0] rsp_wait_us,
   output logic        rsp_cmd_status,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   cmd_type cmd_word;
   rsp_type wr_word, rd_word;
   logic    cmd_valid, cmd_pop, rsp_wr, rsp_full;

   dts_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
      .clock, .reset, .push, .full, .req_type, .req_timer_slot,
      .req_arg_value, .req_time_now, .cmd_valid, .cmd_pop, .cmd_word
   );

   dts_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
      .clock, .reset, .csr_valid, .csr_ready, .csr_wdata, .cmd_valid,
      .cmd_pop, .cmd_word, .rsp_wr, .rsp_full, .rsp_word(wr_word)
   );

   dts_rsp_queue u_rsp (
      .clock, .reset, .wr_en(rsp_wr), .q_full(rsp_full), .wr_word,
      .empty, .pop, .rd_word
   );

   assign rsp_result_kind = rd_word.kind;
   assign rsp_fired_slot  = rd_word.slot;
   assign rsp_wait_us     = rd_word.wait_us;
   assign rsp_cmd_status  = rd_word.status;
   assign rsp_last_result = rd_word.last;

endmodule

// ===== bench/deadline_timer_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
module deadline_timer_scheduler_top_tb;
   import dts_pkg::*;

   localparam int NT = 16;
   localparam int CYCLE_LIMIT = 900000;
   localparam int MAX_REPORTS = 10;
   localparam int SETTLE_CYCLES = 20 * (NT + 1);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_type = OP_CHECK;
   logic [3:0]  req_timer_slot = '0;
   logic [31:0] req_arg_value = '0;
   logic [62:0] req_time_now = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_result_kind;
   logic [3:0]  rsp_fired_slot;
   logic [31:0] rsp_wait_us;
   logic        rsp_cmd_status;
   logic        rsp_last_result;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_wdata = '0;

   deadline_timer_scheduler_top #(.NUM_TIMERS(NT)) u_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_type(req_type), .req_timer_slot(req_timer_slot),
      .req_arg_value(req_arg_value), .req_time_now(req_time_now),
      .empty(empty), .pop(pop), .rsp_result_kind(rsp_result_kind),
      .rsp_fired_slot(rsp_fired_slot), .rsp_wait_us(rsp_wait_us),
      .rsp_cmd_status(rsp_cmd_status), .rsp_last_result(rsp_last_result),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   // Free-running clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the timer table.
   logic [31:0] sh_precision;
   logic        sh_used [NT];
   logic        sh_enabled [NT];
   logic        sh_reload [NT];
   logic [31:0] sh_period [NT];
   logic [62:0] sh_deadline [NT];
   logic [31:0] sh_stamp [NT];
   logic [31:0] sh_counter;

   rsp_type     pending_words [$];
   int          cycle_count = 0;
   int          mismatches = 0;
   int          words_checked = 0;
   int          expiries_seen = 0;
   int          cmds_sent = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic [62:0] clock_us = '0;

   // A directed stimulus row; a typed-in word is compared as well as predicted.
   typedef struct {
      op_type      op;
      logic [3:0]  slot;
      logic [31:0] arg;
      logic [62:0] now;
      logic        typed;
      logic [31:0] typed_wait;
      logic        typed_status;
   } dir_row;

   function automatic void timers_reset();
      sh_precision = PRECISION_RST;
      for (int i = 0; i < NT; i++) begin
         sh_used[i] = 1'b0;
         sh_enabled[i] = 1'b0;
         sh_reload[i] = 1'b0;
         sh_period[i] = '0;
         sh_deadline[i] = NEVER_DEADLINE;
         sh_stamp[i] = '0;
      end
      sh_counter = '0;
   endfunction

   function automatic void arm_timer(int s, logic [62:0] now);
      logic [63:0] sum;
      sum = {1'b0, now} + {32'd0, sh_period[s]};
      sh_deadline[s] = sum[63] ? NEVER_DEADLINE : sum[62:0];
      sh_stamp[s] = sh_counter;
      sh_counter = sh_counter + 32'd1;
   endfunction

   function automatic bit fires_before(int a, int b);
      if (sh_deadline[a] != sh_deadline[b]) return sh_deadline[a] < sh_deadline[b];
      if (sh_stamp[a] != sh_stamp[b]) return sh_stamp[a] > sh_stamp[b];
      return a < b;
   endfunction

   function automatic int earliest_timer(logic [NT-1:0] skip);
      int best;
      best = -1;
      for (int i = 0; i < NT; i++)
         if (sh_enabled[i] && !skip[i])
            if (best < 0 || fires_before(i, best)) best = i;
      return best;
   endfunction

   // Applies one command to the shadow table and queues the words it causes.
   function automatic void predict_command(op_type op, logic [3:0] slot, logic [31:0] arg,
                                           logic [62:0] now);
      logic          status;
      logic [NT-1:0] fired;
      int            s;
      int            f;
      logic [63:0]   due_limit;
      logic [62:0]   gap;
      rsp_type       w;
      s = slot;
      status = 1'b0;
      if (op == OP_CHECK) begin
         status = 1'b0;
      end else if (op == OP_UNKNOWN || s >= NT || (op != OP_CREATE && !sh_used[s])) begin
         status = 1'b1;
      end else begin
         case (op)
            OP_CREATE: begin
               sh_used[s] = 1'b1;
               sh_enabled[s] = 1'b0;
               sh_reload[s] = 1'b1;
               sh_period[s] = arg;
               sh_deadline[s] = NEVER_DEADLINE;
            end
            OP_DELETE: begin
               sh_used[s] = 1'b0;
               sh_enabled[s] = 1'b0;
               sh_reload[s] = 1'b0;
               sh_deadline[s] = NEVER_DEADLINE;
            end
            OP_START: begin
               if (!sh_enabled[s]) begin
                  sh_enabled[s] = 1'b1;
                  arm_timer(s, now);
               end
            end
            OP_PAUSE: begin
               if (sh_enabled[s]) begin
                  sh_enabled[s] = 1'b0;
                  sh_deadline[s] = NEVER_DEADLINE;
               end
            end
            OP_PERIOD: begin
               sh_period[s] = arg;
               if (sh_enabled[s]) arm_timer(s, now);
            end
            default: begin
               sh_reload[s] = (arg != 0);
            end
         endcase
      end
      // Expiry scan: each due timer fires once, in firing order.
      fired = '0;
      due_limit = {1'b0, now} + {32'd0, sh_precision};
      forever begin
         f = earliest_timer(fired);
         if (f < 0) break;
         if (!({1'b0, sh_deadline[f]} < due_limit)) break;
         fired[f] = 1'b1;
         if (sh_reload[f]) begin
            arm_timer(f, now);
         end else begin
            sh_enabled[f] = 1'b0;
            sh_deadline[f] = NEVER_DEADLINE;
         end
         w = '{kind: RESULT_EXPIRY, slot: f[3:0], wait_us: '0, status: status, last: 1'b0};
         pending_words.push_back(w);
      end
      // Summary word with the wait until the next deadline.
      f = earliest_timer('0);
      w = '{kind: RESULT_SUMMARY, slot: '0, wait_us: WAIT_FOREVER, status: status, last: 1'b1};
      if (f >= 0) begin
         if (sh_deadline[f] <= now) begin
            w.wait_us = '0;
         end else begin
            gap = sh_deadline[f] - now;
            w.wait_us = (gap > {31'd0, WAIT_MAX}) ? WAIT_MAX : gap[31:0];
         end
      end
      pending_words.push_back(w);
   endfunction

   // Drives one command word, waiting for the block to take it.
   task automatic send_command(op_type op, logic [3:0] slot, logic [31:0] arg,
                               logic [62:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_type <= op;
      req_timer_slot <= slot;
      req_arg_value <= arg;
      req_time_now <= now;
      predict_command(op, slot, arg, now);
      cmds_sent++;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write, only once every expected word has arrived.
   task automatic write_precision(logic [31:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      sh_precision = value;
   endtask

   // Receiver: pop at random and check each word against the oldest expectation.
   always @(negedge clock) begin
      if (!reset) pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      rsp_type exp_w;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
                  pending_words.size());
         $display("FAIL");
         $finish;
      end
      if (!reset && pop && !empty) begin
         words_checked++;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Unexpected word: kind %0b slot %0d wait %0h", rsp_result_kind,
                        rsp_fired_slot, rsp_wait_us);
         end else begin
            exp_w = pending_words.pop_front();
            if (exp_w.kind == RESULT_EXPIRY) expiries_seen++;
            if (rsp_result_kind !== exp_w.kind || rsp_fired_slot !== exp_w.slot ||
                rsp_wait_us !== exp_w.wait_us || rsp_cmd_status !== exp_w.status ||
                rsp_last_result !== exp_w.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("Mismatch: expected k%0b s%0d w%0h st%0b l%0b, got k%0b s%0d w%0h st%0b l%0b",
                           exp_w.kind, exp_w.slot, exp_w.wait_us, exp_w.status, exp_w.last,
                           rsp_result_kind, rsp_fired_slot, rsp_wait_us, rsp_cmd_status,
                           rsp_last_result);
            end
         end
      end
   end

   // Picks a random time step; mostly small so timers keep falling due.
   function automatic logic [62:0] next_time();
      case ($urandom_range(9))
         0: return clock_us;
         1: return 63'(clock_us + {$urandom, $urandom} % 64'd100000);
         default: return clock_us + 63'($urandom_range(60));
      endcase
   endfunction

   function automatic logic [31:0] rand_period();
      case ($urandom_range(7))
         0: return $urandom;
         1: return 32'd0;
         2: return 32'hFFFF_FFFF;
         default: return $urandom_range(50);
      endcase
   endfunction

   task automatic random_commands(int count);
      op_type      op;
      logic [3:0]  slot;
      logic [31:0] arg;
      for (int n = 0; n < count; n++) begin
         slot = 4'($urandom_range(NT - 1));
         case ($urandom_range(19))
            0, 1, 2: op = OP_CREATE;
            3, 4, 5, 6: op = OP_START;
            7, 8: op = OP_PERIOD;
            9, 10: op = OP_RELOAD;
            11: op = OP_PAUSE;
            12: op = OP_DELETE;
            13: op = OP_UNKNOWN;
            default: op = OP_CHECK;
         endcase
         arg = (op == OP_RELOAD) ? (($urandom_range(2) == 0) ? 32'd0 : $urandom)
                                 : rand_period();
         clock_us = ($urandom_range(60) == 0) ? 63'({$urandom, $urandom}) : next_time();
         send_command(op, slot, arg, clock_us);
      end
   endtask

   dir_row directed [] = '{
      '{OP_CHECK,   4'd0,  32'd0,          63'd0,          1'b1, WAIT_FOREVER, 1'b0},
      '{OP_UNKNOWN, 4'd3,  32'd0,          63'd5,          1'b1, WAIT_FOREVER, 1'b1},
      '{OP_START,   4'd2,  32'd0,          63'd5,          1'b1, WAIT_FOREVER, 1'b1},
      '{OP_DELETE,  4'd2,  32'd0,          63'd5,          1'b1, WAIT_FOREVER, 1'b1},
      '{OP_PAUSE,   4'd9,  32'd0,          63'd5,          1'b1, WAIT_FOREVER, 1'b1},
      '{OP_PERIOD,  4'd9,  32'd7,          63'd5,          1'b1, WAIT_FOREVER, 1'b1},
      '{OP_RELOAD,  4'd9,  32'd1,          63'd5,          1'b1, WAIT_FOREVER, 1'b1},
      '{OP_CREATE,  4'd0,  32'd10,         63'd10,         1'b1, WAIT_FOREVER, 1'b0},
      '{OP_CREATE,  4'd15, 32'hFFFF_FFFF,  63'd10,         1'b1, WAIT_FOREVER, 1'b0},
      '{OP_START,   4'd0,  32'd0,          63'd10,         1'b1, 32'd10,       1'b0},
      '{OP_START,   4'd0,  32'd0,          63'd12,         1'b0, 32'd0,        1'b0},
      '{OP_CREATE,  4'd1,  32'd10,         63'd10,         1'b0, 32'd0,        1'b0},
      '{OP_START,   4'd1,  32'd0,          63'd10,         1'b0, 32'd0,        1'b0},
      '{OP_RELOAD,  4'd1,  32'd0,          63'd10,         1'b0, 32'd0,        1'b0},
      '{OP_CHECK,   4'd0,  32'd0,          63'd20,         1'b0, 32'd0,        1'b0},
      '{OP_START,   4'd15, 32'd0,          63'd20,         1'b0, 32'd0,        1'b0},
      '{OP_PERIOD,  4'd0,  32'd0,          63'd25,         1'b0, 32'd0,        1'b0},
      '{OP_PAUSE,   4'd0,  32'd0,          63'd25,         1'b0, 32'd0,        1'b0},
      '{OP_PAUSE,   4'd0,  32'd0,          63'd25,         1'b0, 32'd0,        1'b0},
      '{OP_CREATE,  4'd5,  32'd1000,       {63{1'b1}} - 63'd2, 1'b0, 32'd0,    1'b0},
      '{OP_START,   4'd5,  32'd0,          {63{1'b1}} - 63'd2, 1'b0, 32'd0,    1'b0},
      '{OP_DELETE,  4'd5,  32'd0,          {63{1'b1}} - 63'd2, 1'b0, 32'd0,    1'b0},
      '{OP_DELETE,  4'd15, 32'd0,          63'd30,         1'b0, 32'd0,        1'b0}
   };

   // Main sequence: reset, directed rows, then random phases at several settings.
   initial begin
      rsp_type typed_w;
      timers_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         if (directed[i].typed) begin
            wait_drained();
            send_command(directed[i].op, directed[i].slot, directed[i].arg, directed[i].now);
            typed_w = pending_words[pending_words.size() - 1];
            if (typed_w.wait_us !== directed[i].typed_wait ||
                typed_w.status !== directed[i].typed_status) begin
               mismatches++;
               $display("Directed row %0d: predicted summary disagrees with table", i);
            end
         end else begin
            send_command(directed[i].op, directed[i].slot, directed[i].arg, directed[i].now);
         end
      end
      clock_us = 63'd100;
      send_idle_pct = 13;
      recv_idle_pct = 65;
      write_precision(32'd0);
      random_commands(70);
      send_idle_pct = 65;
      recv_idle_pct = 13;
      write_precision(32'hFFFF_FFFF);
      random_commands(40);
      write_precision($urandom_range(20));
      random_commands(50);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_precision(32'd1);
      random_commands(70);
      wait_drained();
      $display("Sent %0d commands, checked %0d words including %0d timer expiries",
               cmds_sent, words_checked, expiries_seen);
      $display("Precision settings 0, 1, all ones and a small random value; %0d mismatches",
               mismatches);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
